/* design/mstps_pkg.sv */
// Shared types and codes for the step temperature profile sequencer.
`timescale 1ns / 1ps

package mstps_pkg;

  localparam int SETTING_W = 18;
  localparam int TARGET_W  = 7;
  localparam int MINUTES_W = 11;
  localparam int TEMP_W    = 11;
  localparam int STEP_W    = 3;
  localparam int FRAC_W    = 4;
  localparam int REGS_MAX  = 4;

  // run modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_HOLD = 2'd2;
  localparam logic [1:0] MODE_COOL = 2'd3;

  // input word kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  // end reasons
  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_TIME   = 2'd1;
  localparam logic [1:0] END_ERROR  = 2'd2;
  localparam logic [1:0] END_MANUAL = 2'd3;

  // fault codes
  localparam logic [1:0] FAULT_OK        = 2'd0;
  localparam logic [1:0] FAULT_NO_HEATER = 2'd1;
  localparam logic [1:0] FAULT_NO_SENSOR = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_STEP1   = 3'd0;
  localparam logic [2:0] REG_STEP2   = 3'd1;
  localparam logic [2:0] REG_STEP3   = 3'd2;
  localparam logic [2:0] REG_STEP4   = 3'd3;
  localparam logic [2:0] REG_COOL    = 3'd4;
  localparam logic [2:0] REG_CHILLER = 3'd5;

  localparam logic [6:0] COOL_RESET = 7'd30;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [1:0]           spare;
    logic [1:0]           error_code;
    logic [1:0]           stop_cause;
    logic [MINUTES_W-1:0] minutes_left;
    logic                 pump_on;
    logic                 valve_open;
    logic                 heater_enable;
    logic [TARGET_W-1:0]  target_degrees;
    logic [STEP_W-1:0]    step_number;
    logic [1:0]           run_mode;
  } result_t;

  // input word payload
  typedef struct packed {
    logic [1:0]        spare;
    logic              sensor_present;
    logic              heater_present;
    logic              minute_tick;
    logic [TEMP_W-1:0] temperature;
  } sample_t;

  function automatic logic [TARGET_W-1:0] setting_target(input logic [SETTING_W-1:0] s);
    setting_target = s[TARGET_W-1:0];
  endfunction

  function automatic logic [MINUTES_W-1:0] setting_minutes(input logic [SETTING_W-1:0] s);
    setting_minutes = s[SETTING_W-1:TARGET_W];
  endfunction

endpackage

/* design/multi_step_temperature_profile_sequencer.sv */
// Step temperature profile sequencer: control registers, sequencing logic, result register.
`timescale 1ns / 1ps

// One result word for every input word. Each word is handled combinationally:
// the update of the run state is a few compares and a decrement between the
// state registers and the result register, so a word is accepted on every
// cycle in which the result register is empty or being drained. Result valid
// is registered and rises in the cycle after accept. Steps above STEP_COUNT
// (and above four) read as empty and end the run. Configuration writes take
// effect on the next word and are meant to be done while the block is idle.
module multi_step_temperature_profile_sequencer
  import mstps_pkg::*;
#(
  parameter int STEP_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // temperature[10:0], minute_tick[11], heater_present[12],
                                     // sensor_present[13], zero[15:14]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // run_mode[1:0], step_number[4:2], target_degrees[11:5],
                                     // heater_enable[12], valve_open[13], pump_on[14],
                                     // minutes_left[25:15], stop_cause[27:26],
                                     // error_code[29:28], zero[31:30]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STEP_LIMIT = (STEP_COUNT < REGS_MAX) ? STEP_COUNT : REGS_MAX;

  logic [SETTING_W-1:0] step_setting [REGS_MAX];
  logic [6:0]           cool_done;
  logic                 chiller;

  logic [1:0]           mode_reg, mode_next;
  logic [STEP_W-1:0]    step_reg, step_next, step_adv;
  logic [MINUTES_W-1:0] hold_countdown, hold_next;
  logic [1:0]           reason_reg, reason_next;
  logic [1:0]           fault_reg, fault_next;

  logic                 out_valid;
  result_t              out_word, res;
  sample_t              smp;
  logic                 accept;
  logic [2:0]           reg_idx;
  logic                 cfg_wr;

  logic [SETTING_W-1:0] cur_set, adv_set, new_set;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGS_MAX; i++) step_setting[i] <= '0;
      cool_done <= COOL_RESET;
      chiller   <= 1'b1;
    end else if (cfg_wr) begin
      for (int i = 0; i < REGS_MAX; i++) begin
        if (reg_idx == 3'(i)) step_setting[i] <= pwdata[SETTING_W-1:0];
      end
      if (reg_idx == REG_COOL)    cool_done <= pwdata[6:0];
      if (reg_idx == REG_CHILLER) chiller   <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_STEP1:   prdata = 32'(step_setting[0]);
      REG_STEP2:   prdata = 32'(step_setting[1]);
      REG_STEP3:   prdata = 32'(step_setting[2]);
      REG_STEP4:   prdata = 32'(step_setting[3]);
      REG_COOL:    prdata = 32'(cool_done);
      REG_CHILLER: prdata = 32'(chiller);
      default:     prdata = '0;
    endcase
  end

  // setting of a step; step 0 and steps past the limit read as empty
  function automatic logic [SETTING_W-1:0] setting_of(
    input logic [STEP_W-1:0] step,
    input logic [SETTING_W-1:0] regs [REGS_MAX]
  );
    logic [STEP_W-1:0] idx;
    idx = step - 3'd1;
    if (step == '0 || 32'(step) > STEP_LIMIT) setting_of = '0;
    else setting_of = regs[idx[1:0]];
  endfunction

  // ---------------- sequencing ----------------
  assign smp      = sample_t'(s_axis_tdata);
  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign step_adv = step_reg + 3'd1;
  assign cur_set  = setting_of(step_reg, step_setting);
  assign adv_set  = setting_of(step_adv, step_setting);

  always_comb begin
    mode_next   = mode_reg;
    step_next   = step_reg;
    hold_next   = hold_countdown;
    reason_next = reason_reg;
    fault_next  = fault_reg;
    case (s_axis_tuser)
      KIND_SAMPLE: begin
        case (mode_reg)
          MODE_HEAT: begin
            if (smp.temperature >= {setting_target(cur_set), 4'b0}) begin
              mode_next = MODE_HOLD;
              hold_next = setting_minutes(cur_set);
            end
          end
          MODE_HOLD: begin
            if (smp.minute_tick) begin
              if (hold_countdown <= 11'd1) begin
                step_next = step_adv;
                hold_next = '0;
                if (setting_minutes(adv_set) == '0 || setting_target(adv_set) == '0) begin
                  if (chiller) begin
                    mode_next = MODE_COOL;
                  end else begin
                    mode_next   = MODE_OFF;
                    step_next   = '0;
                    reason_next = END_TIME;
                  end
                end else begin
                  mode_next = MODE_HEAT;
                end
              end else begin
                hold_next = hold_countdown - 11'd1;
              end
            end
          end
          MODE_COOL: begin
            if (smp.temperature <= {cool_done, 4'b0}) begin
              mode_next   = MODE_OFF;
              step_next   = '0;
              hold_next   = '0;
              reason_next = END_TIME;
            end
          end
          default: ;
        endcase
      end
      KIND_START: begin
        if (mode_reg != MODE_OFF) begin
          mode_next   = MODE_OFF;
          step_next   = '0;
          hold_next   = '0;
          reason_next = END_MANUAL;
        end else if (!smp.heater_present) begin
          fault_next  = FAULT_NO_HEATER;
          reason_next = END_ERROR;
        end else if (!smp.sensor_present) begin
          fault_next  = FAULT_NO_SENSOR;
          reason_next = END_ERROR;
        end else begin
          fault_next  = FAULT_OK;
          reason_next = END_NONE;
          mode_next   = MODE_HEAT;
          step_next   = 3'd1;
          hold_next   = '0;
        end
      end
      KIND_STOP: begin
        mode_next   = MODE_OFF;
        step_next   = '0;
        hold_next   = '0;
        reason_next = END_MANUAL;
      end
      default: ;
    endcase
  end

  // result shows the state after the update
  assign new_set = setting_of(step_next, step_setting);

  always_comb begin
    res                = '0;
    res.run_mode       = mode_next;
    res.step_number    = step_next;
    res.target_degrees = setting_target(new_set);
    res.heater_enable  = (mode_next == MODE_HEAT) || (mode_next == MODE_HOLD);
    res.valve_open     = (mode_next == MODE_COOL);
    res.pump_on        = (mode_next != MODE_OFF);
    res.stop_cause     = reason_next;
    res.error_code     = fault_next;
    if (mode_next == MODE_HOLD)      res.minutes_left = hold_next;
    else if (mode_next == MODE_HEAT) res.minutes_left = setting_minutes(new_set);
    else                             res.minutes_left = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_OFF;
      step_reg       <= '0;
      hold_countdown <= '0;
      reason_reg     <= END_NONE;
      fault_reg      <= FAULT_OK;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode_reg       <= mode_next;
        step_reg       <= step_next;
        hold_countdown <= hold_next;
        reason_reg     <= reason_next;
        fault_reg      <= fault_next;
        out_valid      <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_word <= res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = 32'(out_word);

endmodule

/* dv/tb_multi_step_temperature_profile_sequencer.sv */
// Self-checking testbench for the step temperature profile sequencer.
`timescale 1ns / 1ps

module tb_multi_step_temperature_profile_sequencer;
  import mstps_pkg::*;

  localparam int STEPS = 4;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  multi_step_temperature_profile_sequencer #(.STEP_COUNT(STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Sequencer model plus the queue of status words it predicts.
  class profile_scoreboard;
    logic [SETTING_W-1:0] step_cfg [REGS_MAX];
    logic [TARGET_W-1:0]  cool_deg;
    logic                 chiller;
    logic [1:0]           mode;
    logic [STEP_W-1:0]    step;
    logic [MINUTES_W-1:0] countdown;
    logic [1:0]           reason;
    logic [1:0]           fault;
    result_t              expected_status [$];
    int words, results, errors, runs, holds, coolings, faults;

    function new();
      foreach (step_cfg[i]) step_cfg[i] = '0;
      cool_deg = COOL_RESET;
      chiller = 1'b1;
      mode = MODE_OFF;
      step = '0;
      countdown = '0;
      reason = END_NONE;
      fault = FAULT_OK;
      words = 0; results = 0; errors = 0;
      runs = 0; holds = 0; coolings = 0; faults = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
        REG_STEP1, REG_STEP2, REG_STEP3, REG_STEP4: step_cfg[idx[1:0]] = val[SETTING_W-1:0];
        REG_COOL:    cool_deg = val[TARGET_W-1:0];
        REG_CHILLER: chiller = val[0];
        default: ;
      endcase
    endfunction

    // steps past the register bank read as empty
    function logic [SETTING_W-1:0] cfg_of(input logic [STEP_W-1:0] s);
      logic [STEP_W-1:0] k;
      k = s - 3'd1;
      if (s >= 1 && s <= 4 && s <= STEPS) return step_cfg[k[1:0]];
      return '0;
    endfunction

    function logic [TARGET_W-1:0] target_of(input logic [STEP_W-1:0] s);
      logic [SETTING_W-1:0] c;
      c = cfg_of(s);
      return c[TARGET_W-1:0];
    endfunction

    function logic [MINUTES_W-1:0] minutes_of(input logic [STEP_W-1:0] s);
      logic [SETTING_W-1:0] c;
      c = cfg_of(s);
      return c[SETTING_W-1:TARGET_W];
    endfunction

    function void finish_run(input logic [1:0] why);
      mode = MODE_OFF;
      step = '0;
      countdown = '0;
      reason = why;
    endfunction

    function void next_step();
      step = step + 3'd1;
      countdown = '0;
      if (minutes_of(step) == 0 || target_of(step) == 0) begin
        if (chiller) begin
          mode = MODE_COOL;
          coolings++;
        end else begin
          finish_run(END_TIME);
        end
      end else begin
        mode = MODE_HEAT;
      end
    endfunction

    function void note_word(input logic [1:0] kind, input sample_t w);
      result_t r;
      words++;
      case (kind)
        KIND_SAMPLE: begin
          case (mode)
            MODE_HEAT: if (w.temperature >= {target_of(step), 4'b0000}) begin
              mode = MODE_HOLD;
              countdown = minutes_of(step);
              holds++;
            end
            MODE_HOLD: if (w.minute_tick) begin
              if (countdown <= 1) next_step();
              else countdown = countdown - 1'b1;
            end
            MODE_COOL: if (w.temperature <= {cool_deg, 4'b0000}) finish_run(END_TIME);
            default: ;
          endcase
        end
        KIND_START: begin
          if (mode != MODE_OFF) begin
            finish_run(END_MANUAL);
          end else begin
            fault = FAULT_OK;
            reason = END_NONE;
            if (!w.heater_present) begin
              fault = FAULT_NO_HEATER;
              reason = END_ERROR;
              faults++;
            end else if (!w.sensor_present) begin
              fault = FAULT_NO_SENSOR;
              reason = END_ERROR;
              faults++;
            end else begin
              mode = MODE_HEAT;
              step = 3'd1;
              countdown = '0;
              runs++;
            end
          end
        end
        KIND_STOP: finish_run(END_MANUAL);
        default: ;
      endcase

      r = '0;
      r.run_mode = mode;
      r.step_number = step;
      r.target_degrees = target_of(step);
      r.heater_enable = (mode == MODE_HEAT || mode == MODE_HOLD);
      r.valve_open = (mode == MODE_COOL);
      r.pump_on = (mode != MODE_OFF);
      if (mode == MODE_HOLD) r.minutes_left = countdown;
      else if (mode == MODE_HEAT) r.minutes_left = minutes_of(step);
      r.stop_cause = reason;
      r.error_code = fault;
      expected_status.push_back(r);
    endfunction

    function void check_status(input logic [31:0] data);
      result_t got;
      result_t exp;
      string bad;
      got = data;
      results++;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected status word %h", data);
        return;
      end
      exp = expected_status.pop_front();
      bad = "";
      if (got.run_mode !== exp.run_mode) bad = {bad, " run_mode"};
      if (got.step_number !== exp.step_number) bad = {bad, " step_number"};
      if (got.target_degrees !== exp.target_degrees) bad = {bad, " target_degrees"};
      if (got.heater_enable !== exp.heater_enable) bad = {bad, " heater_enable"};
      if (got.valve_open !== exp.valve_open) bad = {bad, " valve_open"};
      if (got.pump_on !== exp.pump_on) bad = {bad, " pump_on"};
      if (got.minutes_left !== exp.minutes_left) bad = {bad, " minutes_left"};
      if (got.stop_cause !== exp.stop_cause) bad = {bad, " stop_cause"};
      if (got.error_code !== exp.error_code) bad = {bad, " error_code"};
      if (got.spare !== exp.spare) bad = {bad, " spare"};
      if (bad != "") begin
        errors++;
        if (errors <= 10)
          $display("status word %0d wrong in%s: expected %h, got %h",
                   results, bad, 32'(exp), 32'(got));
      end
    endfunction
  endclass

  profile_scoreboard scb;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // status side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) scb.check_status(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic sample_t pack_word(input int temp, input bit tick,
                                        input bit heater, input bit sensor);
    sample_t w;
    w = '0;
    w.temperature = 11'(temp);
    w.minute_tick = tick;
    w.heater_present = heater;
    w.sensor_present = sensor;
    return w;
  endfunction

  // valid stays high from one word to the next unless a gap is inserted
  task automatic send_word(input logic [1:0] kind, input sample_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= w;
    do @(posedge clk); while (!s_axis_tready);
    scb.note_word(kind, w);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    scb.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (scb.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed profile traffic steered by the model state, some noise
  task automatic pick_word(output logic [1:0] kind, output sample_t w);
    int roll;
    int r2;
    logic [TEMP_W-1:0] lim;
    roll = $urandom_range(0, 99);
    r2 = $urandom_range(0, 9);
    w = pack_word($urandom_range(0, 2047), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    kind = KIND_SAMPLE;
    if (roll < 6) begin
      kind = 2'($urandom_range(0, 3));
    end else if (scb.mode == MODE_OFF) begin
      kind = (roll >= 92) ? KIND_SAMPLE : KIND_START;
      if (roll < 75) begin
        w.heater_present = 1'b1;
        w.sensor_present = 1'b1;
      end
    end else if (roll < 9) begin
      kind = KIND_START;
    end else if (roll < 10 || (scb.mode == MODE_HOLD && scb.countdown > 30 && roll < 16)) begin
      kind = KIND_STOP;
    end else begin
      case (scb.mode)
        MODE_HEAT: begin
          lim = {scb.target_of(scb.step), 4'b0000};
          if (r2 < 3) w.temperature = lim - 11'($urandom_range(0, 1));
          else if (r2 < 7) w.temperature = 11'($urandom_range(0, lim));
        end
        MODE_HOLD: w.minute_tick = (r2 < 7);
        MODE_COOL: begin
          lim = {scb.cool_deg, 4'b0000};
          if (r2 < 3) w.temperature = lim + 11'($urandom_range(0, 1));
          else if (r2 < 7) w.temperature = 11'($urandom_range(lim, 2047));
        end
        default: ;
      endcase
    end
  endtask

  task automatic random_setup();
    int roll;
    logic [SETTING_W-1:0] s;
    for (int i = 0; i < 4; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) s = '0;
      else if (roll < 15) s = 18'd184319;
      else if (roll < 20) s = {11'd0, 7'($urandom_range(1, 100))};
      else if (roll < 24) s = {11'($urandom_range(1, 6)), 7'd0};
      else if (roll < 30) s = {11'($urandom_range(1, 4)), 7'($urandom_range(101, 127))};
      else s = {11'($urandom_range(1, 6)), 7'($urandom_range(1, 100))};
      write_reg(3'(REG_STEP1 + i), 32'(s));
    end
    roll = $urandom_range(0, 99);
    if (roll < 15) write_reg(REG_COOL, 32'd10);
    else if (roll < 30) write_reg(REG_COOL, 32'd90);
    else write_reg(REG_COOL, 32'($urandom_range(10, 90)));
    write_reg(REG_CHILLER, 32'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int count);
    logic [1:0] kind;
    sample_t w;
    for (int i = 0; i < count; i++) begin
      pick_word(kind, w);
      send_word(kind, w);
    end
    wait_idle();
  endtask

  initial begin
    #5_000_000;
    $display("timeout: status words still outstanding");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    scb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: error checks, a full profile, zero-time end, cooling end
    write_reg(REG_STEP1, 32'({11'd2, 7'd45}));
    write_reg(REG_STEP2, 32'({11'd1, 7'd100}));
    write_reg(REG_STEP3, 32'({11'd0, 7'd60}));
    write_reg(REG_STEP4, 32'h3FFFF);
    write_reg(REG_COOL, 32'd10);
    write_reg(REG_CHILLER, 32'd1);
    send_word(KIND_UNUSED, pack_word(0, 0, 0, 0));
    send_word(KIND_SAMPLE, pack_word(2047, 1, 1, 1));
    send_word(KIND_STOP, pack_word(0, 0, 0, 0));
    send_word(KIND_START, pack_word(0, 0, 0, 0));
    send_word(KIND_START, pack_word(0, 0, 1, 0));
    send_word(KIND_START, pack_word(0, 0, 1, 1));
    send_word(KIND_SAMPLE, pack_word(719, 1, 0, 0));
    send_word(KIND_SAMPLE, pack_word(720, 0, 0, 0));
    send_word(KIND_SAMPLE, pack_word(0, 1, 0, 0));
    send_word(KIND_SAMPLE, pack_word(0, 1, 0, 0));
    send_word(KIND_SAMPLE, pack_word(1600, 1, 0, 0));
    send_word(KIND_SAMPLE, pack_word(0, 1, 0, 0));
    send_word(KIND_SAMPLE, pack_word(161, 0, 0, 0));
    send_word(KIND_SAMPLE, pack_word(160, 0, 0, 0));
    send_word(KIND_START, pack_word(0, 0, 1, 1));
    send_word(KIND_START, pack_word(0, 0, 0, 0));
    wait_idle();

    // empty first step, no chiller
    write_reg(REG_STEP1, 32'd0);
    write_reg(REG_STEP2, 32'd0);
    write_reg(REG_CHILLER, 32'd0);
    send_word(KIND_START, pack_word(0, 0, 1, 1));
    send_word(KIND_SAMPLE, pack_word(0, 0, 0, 0));
    send_word(KIND_SAMPLE, pack_word(0, 1, 0, 0));
    wait_idle();

    // all four steps, then past the bank into cooling
    for (int i = 0; i < 4; i++) write_reg(3'(REG_STEP1 + i), 32'({11'd1, 7'd1}));
    write_reg(REG_COOL, 32'd90);
    write_reg(REG_CHILLER, 32'd1);
    send_word(KIND_START, pack_word(0, 0, 1, 1));
    for (int i = 0; i < 4; i++) begin
      send_word(KIND_SAMPLE, pack_word(16, 0, 0, 0));
      send_word(KIND_SAMPLE, pack_word(0, 1, 0, 0));
    end
    send_word(KIND_SAMPLE, pack_word(1440, 0, 0, 0));
    wait_idle();

    send_idle_pct = 31;
    recv_idle_pct = 66;
    random_setup();
    run_phase(258);
    random_setup();
    run_phase(258);
    send_idle_pct = 66;
    recv_idle_pct = 31;
    random_setup();
    run_phase(258);
    random_setup();
    run_phase(258);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_setup();
    run_phase(258);
    random_setup();
    run_phase(258);

    $display("Checked %0d status words for %0d input words, %0d mismatches.",
             scb.results, scb.words, scb.errors);
    $display("Runs started %0d, holds entered %0d, cooling phases %0d, start faults %0d.",
             scb.runs, scb.holds, scb.coolings, scb.faults);
    if (scb.errors == 0 && scb.expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
